// ===== src/amgb_pkg.sv =====
// Package for the adjacency matrix graph builder: status codes, microcode types and program.
`default_nettype none

package amgb_pkg;

  localparam int KEY_W = 32;
  localparam int STATUS_W = 3;
  localparam int VCOUNT_W = 7;
  localparam int ACOUNT_W = 13;
  localparam int UPC_W = 4;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EXISTS  = 3'd4;

  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [3:0] {
    OP_WAIT,
    OP_SCAN,
    OP_NOP,
    OP_VTX_CHECK,
    OP_VTX_ADD,
    OP_ARC_RDT,
    OP_ARC_RDH,
    OP_ARC_TEST,
    OP_ARC_WT,
    OP_ARC_WH,
    OP_FINISH
  } op_t;

  typedef enum logic [3:0] {
    J_NEVER,
    J_ALWAYS,
    J_NO_INPUT,
    J_SCAN_MORE,
    J_IS_ARC,
    J_VTX_FAIL,
    J_KEY_MISSING,
    J_ARC_EXISTS,
    J_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic scan_more;
    logic is_arc;
    logic vtx_fail;
    logic key_missing;
    logic arc_exists;
    logic out_free;
  } cond_flags_t;

  typedef struct packed {
    logic scan_more;
    logic full;
    logic found_a;
    logic found_b;
  } key_flags_t;

  localparam upc_t UA_WAIT = 4'd0;
  localparam upc_t UA_SCAN = 4'd1;
  localparam upc_t UA_DISP = 4'd2;
  localparam upc_t UA_VCHK = 4'd3;
  localparam upc_t UA_VADD = 4'd4;
  localparam upc_t UA_ARDT = 4'd5;
  localparam upc_t UA_ARDH = 4'd6;
  localparam upc_t UA_ATST = 4'd7;
  localparam upc_t UA_AWT  = 4'd8;
  localparam upc_t UA_AWH  = 4'd9;
  localparam upc_t UA_FIN  = 4'd10;
  localparam upc_t UA_HOLD = 4'd11;

  // A step jumps to its target when its condition holds and falls through otherwise.
  function automatic ctrl_t ucode_rom(input upc_t addr);
    ctrl_t w;
    case (addr)
      UA_WAIT: w = '{op: OP_WAIT,      cond: J_NO_INPUT,    target: UA_WAIT};
      UA_SCAN: w = '{op: OP_SCAN,      cond: J_SCAN_MORE,   target: UA_SCAN};
      UA_DISP: w = '{op: OP_NOP,       cond: J_IS_ARC,      target: UA_ARDT};
      UA_VCHK: w = '{op: OP_VTX_CHECK, cond: J_VTX_FAIL,    target: UA_FIN};
      UA_VADD: w = '{op: OP_VTX_ADD,   cond: J_ALWAYS,      target: UA_FIN};
      UA_ARDT: w = '{op: OP_ARC_RDT,   cond: J_KEY_MISSING, target: UA_FIN};
      UA_ARDH: w = '{op: OP_ARC_RDH,   cond: J_NEVER,       target: UA_WAIT};
      UA_ATST: w = '{op: OP_ARC_TEST,  cond: J_ARC_EXISTS,  target: UA_FIN};
      UA_AWT:  w = '{op: OP_ARC_WT,    cond: J_NEVER,       target: UA_WAIT};
      UA_AWH:  w = '{op: OP_ARC_WH,    cond: J_ALWAYS,      target: UA_FIN};
      UA_FIN:  w = '{op: OP_FINISH,    cond: J_OUT_FREE,    target: UA_WAIT};
      UA_HOLD: w = '{op: OP_NOP,       cond: J_ALWAYS,      target: UA_FIN};
      default: w = '{op: OP_NOP,       cond: J_ALWAYS,      target: UA_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== src/amgb_sequencer.sv =====
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`default_nettype none

module amgb_sequencer (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire amgb_pkg::cond_flags_t flags,
  output amgb_pkg::ctrl_t           ctrl
);

  amgb_pkg::upc_t upc;
  amgb_pkg::upc_t upc_next;
  logic           take;

  assign ctrl = amgb_pkg::ucode_rom(upc);

  always_comb begin
    case (ctrl.cond)
      amgb_pkg::J_NEVER:       take = 1'b0;
      amgb_pkg::J_ALWAYS:      take = 1'b1;
      amgb_pkg::J_NO_INPUT:    take = !flags.in_valid;
      amgb_pkg::J_SCAN_MORE:   take = flags.scan_more;
      amgb_pkg::J_IS_ARC:      take = flags.is_arc;
      amgb_pkg::J_VTX_FAIL:    take = flags.vtx_fail;
      amgb_pkg::J_KEY_MISSING: take = flags.key_missing;
      amgb_pkg::J_ARC_EXISTS:  take = flags.arc_exists;
      amgb_pkg::J_OUT_FREE:    take = flags.out_free;
      default:                 take = 1'b1;
    endcase
    upc_next = take ? ctrl.target : upc + amgb_pkg::upc_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= amgb_pkg::UA_WAIT;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/amgb_key_table.sv =====
// Vertex key table: key memory, vertex count and the scan that looks up both keys at once.
`default_nettype none

module amgb_key_table #(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire amgb_pkg::op_t                 op,
  input  wire logic                          load,
  input  wire logic [amgb_pkg::KEY_W-1:0]    load_key_a,
  input  wire logic [amgb_pkg::KEY_W-1:0]    load_key_b,
  output amgb_pkg::key_flags_t               flags,
  output logic [$clog2(MAX_VERTICES)-1:0]    idx_a,
  output logic [$clog2(MAX_VERTICES)-1:0]    idx_b,
  output logic [$clog2(MAX_VERTICES+1)-1:0]  count
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  logic [amgb_pkg::KEY_W-1:0] keys [MAX_VERTICES];
  logic [amgb_pkg::KEY_W-1:0] key_a;
  logic [amgb_pkg::KEY_W-1:0] key_b;
  logic [amgb_pkg::KEY_W-1:0] rd_key;
  logic [IW-1:0]              rd_index;
  logic                       rd_valid;
  logic [CW-1:0]              idx;
  logic                       found_a;
  logic                       found_b;
  logic                       scan_more;
  logic                       do_read;

  assign scan_more = (idx != count);
  assign do_read   = (op == amgb_pkg::OP_SCAN) && scan_more;

  assign flags.scan_more = scan_more;
  assign flags.full      = (count == CW'(MAX_VERTICES));
  assign flags.found_a   = found_a;
  assign flags.found_b   = found_b;

  always_ff @(posedge clk) begin
    if (do_read) begin
      rd_key <= keys[idx[IW-1:0]];
    end
    if (op == amgb_pkg::OP_VTX_ADD) begin
      keys[count[IW-1:0]] <= key_a;
    end
  end

  // The compare of a word read in the last scan step happens in the step after it,
  // so the found flags are final once the scan has fallen through.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      idx      <= '0;
      rd_valid <= 1'b0;
      found_a  <= 1'b0;
      found_b  <= 1'b0;
    end else begin
      rd_valid <= do_read;
      if (load) begin
        idx     <= '0;
        found_a <= 1'b0;
        found_b <= 1'b0;
      end else begin
        if (do_read) begin
          idx <= idx + CW'(1);
        end
        if (rd_valid && (rd_key == key_a) && !found_a) begin
          found_a <= 1'b1;
        end
        if (rd_valid && (rd_key == key_b) && !found_b) begin
          found_b <= 1'b1;
        end
      end
      if (op == amgb_pkg::OP_VTX_ADD) begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key_a <= load_key_a;
      key_b <= load_key_b;
    end
    if (do_read) begin
      rd_index <= idx[IW-1:0];
    end
    if (rd_valid && (rd_key == key_a) && !found_a) begin
      idx_a <= rd_index;
    end
    if (rd_valid && (rd_key == key_b) && !found_b) begin
      idx_b <= rd_index;
    end
  end

endmodule

`default_nettype wire

// ===== src/amgb_adj_matrix.sv =====
// Adjacency matrix: row memory with per-row valid bits, arc test and arc count.
`default_nettype none

module amgb_adj_matrix #(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire amgb_pkg::op_t                               op,
  input  wire logic                                        directed,
  input  wire logic [$clog2(MAX_VERTICES)-1:0]             idx_t,
  input  wire logic [$clog2(MAX_VERTICES)-1:0]             idx_h,
  input  wire logic [$clog2(MAX_VERTICES)-1:0]             idx_new,
  output logic                                             exists,
  output logic [$clog2(MAX_VERTICES*MAX_VERTICES+1)-1:0]   arc_count
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int AW = $clog2(MAX_VERTICES * MAX_VERTICES + 1);

  logic [MAX_VERTICES-1:0] rows [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_valid;
  logic [MAX_VERTICES-1:0] rd_raw;
  logic                    rd_ok;
  logic [MAX_VERTICES-1:0] rd_row;
  logic [MAX_VERTICES-1:0] row_t;
  logic                    hit_th;
  logic                    rd_en;
  logic [IW-1:0]           rd_addr;
  logic                    wr_en;
  logic [IW-1:0]           wr_addr;
  logic [MAX_VERTICES-1:0] wr_data;

  // A row never written since reset reads as all zeros.
  assign rd_row = rd_ok ? rd_raw : '0;
  assign exists = hit_th || (!directed && rd_row[idx_t]);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_t;
    wr_en   = 1'b0;
    wr_addr = idx_t;
    wr_data = '0;
    case (op)
      amgb_pkg::OP_ARC_RDT: begin
        rd_en = 1'b1;
      end
      amgb_pkg::OP_ARC_RDH: begin
        rd_en   = 1'b1;
        rd_addr = idx_h;
      end
      amgb_pkg::OP_VTX_ADD: begin
        wr_en   = 1'b1;
        wr_addr = idx_new;
      end
      amgb_pkg::OP_ARC_WT: begin
        wr_en   = 1'b1;
        wr_data = row_t | (MAX_VERTICES'(1) << idx_h);
      end
      amgb_pkg::OP_ARC_WH: begin
        // The head row was read before the tail row was written; for a self
        // loop both writes carry the same word.
        wr_en   = !directed;
        wr_addr = idx_h;
        wr_data = rd_row | (MAX_VERTICES'(1) << idx_t);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_raw <= rows[rd_addr];
    end
    if (wr_en) begin
      rows[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      arc_count <= '0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (op == amgb_pkg::OP_ARC_WH) begin
        arc_count <= arc_count + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_ok <= row_valid[rd_addr];
    end
    if (op == amgb_pkg::OP_ARC_RDH) begin
      row_t  <= rd_row;
      hit_th <= rd_row[idx_h];
    end
  end

endmodule

`default_nettype wire

// ===== src/adjacency_matrix_graph_builder.sv =====
// Top level of the adjacency matrix graph builder: sequencer, key table, matrix and output register.
//
//  Channel  Handshake             Payload
//  -------  --------------------  ---------------------------------------------
//  config   cfg_valid, cfg_ready  cfg_data (graph_directed, 1 = directed)
//  input    in_valid, in_stall    func, vertex_key, second_key
//  output   out_valid, out_stall  status, vertex_count, arc_count
//
// A vertex insert and an arc insert both first scan the N stored vertices:
// the key scan reads one table word a cycle and compares it against both keys.
// A failed item ends earlier.
// Reset is synchronous; it clears the counts and the row valid bits, and the key
// table holds nothing until written. A finished word waits in the output register
// while the next item is taken; a second finished word waits for that register.
`default_nettype none

module adjacency_matrix_graph_builder #(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic                                  cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  func,
  input  wire logic signed [amgb_pkg::KEY_W-1:0]     vertex_key,
  input  wire logic signed [amgb_pkg::KEY_W-1:0]     second_key,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [amgb_pkg::STATUS_W-1:0]              status,
  output logic [amgb_pkg::VCOUNT_W-1:0]              vertex_count,
  output logic [amgb_pkg::ACOUNT_W-1:0]              arc_count
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int AW = $clog2(MAX_VERTICES * MAX_VERTICES + 1);

  amgb_pkg::ctrl_t        ctrl;
  amgb_pkg::cond_flags_t  cflags;
  amgb_pkg::key_flags_t   kflags;
  logic [IW-1:0]          idx_a;
  logic [IW-1:0]          idx_b;
  logic [CW-1:0]          count;
  logic [AW-1:0]          arcs;
  logic                   exists;
  logic                   accept;
  logic                   out_free;
  logic                   out_load;
  logic                   graph_directed;
  logic                   is_arc;
  logic [amgb_pkg::STATUS_W-1:0] result;

  assign cfg_ready = 1'b1;
  assign in_stall  = (ctrl.op != amgb_pkg::OP_WAIT);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = (ctrl.op == amgb_pkg::OP_FINISH) && out_free;

  assign cflags.in_valid    = in_valid;
  assign cflags.scan_more   = kflags.scan_more;
  assign cflags.is_arc      = is_arc;
  assign cflags.vtx_fail    = kflags.found_a || kflags.full;
  assign cflags.key_missing = !(kflags.found_a && kflags.found_b);
  assign cflags.arc_exists  = exists;
  assign cflags.out_free    = out_free;

  amgb_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (cflags),
    .ctrl  (ctrl)
  );

  amgb_key_table #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_keys (
    .clk        (clk),
    .rst        (rst),
    .op         (ctrl.op),
    .load       (accept),
    .load_key_a (vertex_key),
    .load_key_b (second_key),
    .flags      (kflags),
    .idx_a      (idx_a),
    .idx_b      (idx_b),
    .count      (count)
  );

  amgb_adj_matrix #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_adj (
    .clk       (clk),
    .rst       (rst),
    .op        (ctrl.op),
    .directed  (graph_directed),
    .idx_t     (idx_a),
    .idx_h     (idx_b),
    .idx_new   (count[IW-1:0]),
    .exists    (exists),
    .arc_count (arcs)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      graph_directed <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        graph_directed <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_arc <= func;
    end
    case (ctrl.op)
      amgb_pkg::OP_VTX_CHECK: begin
        if (kflags.found_a) begin
          result <= amgb_pkg::ST_DUP;
        end else if (kflags.full) begin
          result <= amgb_pkg::ST_FULL;
        end else begin
          result <= amgb_pkg::ST_OK;
        end
      end
      amgb_pkg::OP_ARC_RDT: begin
        result <= amgb_pkg::ST_MISSING;
      end
      amgb_pkg::OP_ARC_TEST: begin
        result <= exists ? amgb_pkg::ST_EXISTS : amgb_pkg::ST_OK;
      end
      default: begin
        result <= result;
      end
    endcase
    if (out_load) begin
      status       <= result;
      vertex_count <= amgb_pkg::VCOUNT_W'(count);
      arc_count    <= amgb_pkg::ACOUNT_W'(arcs);
    end
  end

endmodule

`default_nettype wire

// ===== src/amgb_checker.sv =====
// Port-level checker for the graph builder and the bind that attaches it.
`default_nettype none

module amgb_checker #(
  parameter int MAX_VERTICES = 64
) (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                in_valid,
  input wire logic                                in_stall,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic [amgb_pkg::STATUS_W-1:0]       status,
  input wire logic [amgb_pkg::VCOUNT_W-1:0]       vertex_count,
  input wire logic [amgb_pkg::ACOUNT_W-1:0]       arc_count
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(vertex_count)
      && $stable(arc_count))
    else $error("stalled result word changed");

  // Work on an accepted item blocks the input for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an accept");

  // A full table is reported only with the full vertex count.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == amgb_pkg::ST_FULL) |->
      vertex_count == amgb_pkg::VCOUNT_W'(MAX_VERTICES))
    else $error("table full reported below capacity");

  // Reset leaves no result word pending.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind adjacency_matrix_graph_builder amgb_checker #(
  .MAX_VERTICES (MAX_VERTICES)
) u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .vertex_count (vertex_count),
  .arc_count    (arc_count)
);

`default_nettype wire
